// File: design/ir_frame_carrier_transmitter_macros.svh
// Assertion macros used by the IR frame transmitter checker.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef IR_FRAME_CARRIER_TRANSMITTER_MACROS_SVH
`define IR_FRAME_CARRIER_TRANSMITTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define IRFCT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("irfct assertion failed");

// next-cycle implication, disabled during reset
`define IRFCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("irfct assertion failed");

`endif

// File: design/irfct_pkg.sv
// Shared constants, codes and types of the IR frame carrier transmitter.
// No dependencies; used by the top level and its checker.
package irfct_pkg;

	localparam int FRAME_BITS = 32;
	localparam int IDX_W      = $clog2(FRAME_BITS);
	localparam int BITS_W     = IDX_W + 1;
	localparam int PULSE_W    = 8;
	localparam int TICK_W     = PULSE_W + 1;

	localparam logic [PULSE_W-1:0] PULSE_RESET = 8'd16;

	// item kind carried in s_axis_tuser
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// status codes seen on the result
	localparam logic [1:0] STATUS_EMPTY   = 2'd0;
	localparam logic [1:0] STATUS_QUEUED  = 2'd1;
	localparam logic [1:0] STATUS_SENDING = 2'd2;
	localparam logic [1:0] STATUS_DONE    = 2'd3;

	typedef enum logic [3:0] {
		S_EMPTY   = 4'b0001,
		S_QUEUED  = 4'b0010,
		S_SENDING = 4'b0100,
		S_DONE    = 4'b1000
	} send_state_t;

	typedef struct packed {
		logic       accepted;
		logic [1:0] status;
		logic [1:0] drive;
	} result_t;

endpackage

// File: design/ir_frame_carrier_transmitter.sv
// Top level of the IR frame carrier transmitter: frame load, bit timing and
// carrier gating, with an output register and a skid stage. Uses irfct_pkg.
// A result passes through the output register, or the skid stage and then the output register, before m_axis.
// Throughput: one item per cycle while s_axis_tready is high; the frame state is updated in the accept cycle.
// s_axis_tready drops only while the skid stage holds an item behind a stalled output.
// Reset: asynchronous, clears status to empty, drive off, pulse_half_ticks to 16.
module ir_frame_carrier_transmitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,      // pulse_half_ticks
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] emitter_mask, [9:2] group_id, [13:10] team_id, [21:14] player_id,
	// [26:22] gun_id, [29:27] extra_bits, [31:30] zero
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tuser,   // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [1:0] drive, [3:2] status, [4] accepted, [7:5] zero
);

	logic [irfct_pkg::PULSE_W-1:0] pulse_half_q;
	irfct_pkg::send_state_t        state_q, state_n;
	logic [31:0]                   frame_q, frame_n;
	logic [irfct_pkg::BITS_W-1:0]  bits_left_q, bits_left_n;
	logic [irfct_pkg::TICK_W-1:0]  tick_q, tick_n;
	logic                          phase_q, phase_n;
	logic [1:0]                    fire_mask_q, fire_mask_n;
	logic [1:0]                    pin_q, pin_n;
	logic                          accepted_c;
	logic [1:0]                    status_c;
	logic [31:0]                   load_word;
	irfct_pkg::result_t            res_c, out_data_q, skid_data_q;
	logic                          out_valid_q, skid_valid_q;
	logic                          in_acc;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !skid_valid_q;

	// start pair, fields, then parity over the rest and the closing 1
	always_comb begin
		load_word = {2'b11, s_axis_tdata[9:2], s_axis_tdata[13:10], s_axis_tdata[21:14],
			s_axis_tdata[26:22], s_axis_tdata[29:27], 2'b01};
		load_word[1] = ^load_word;
	end

	always_comb begin
		irfct_pkg::send_state_t       st;
		logic [irfct_pkg::BITS_W-1:0] bl;
		logic [irfct_pkg::TICK_W-1:0] tc;
		logic [irfct_pkg::TICK_W-1:0] tc_inc;
		logic [irfct_pkg::IDX_W-1:0]  bit_idx;
		logic                         ph;
		logic                         cur_bit;

		state_n     = state_q;
		frame_n     = frame_q;
		bits_left_n = bits_left_q;
		tick_n      = tick_q;
		phase_n     = phase_q;
		fire_mask_n = fire_mask_q;
		pin_n       = pin_q;
		accepted_c  = 1'b0;
		st          = state_q;
		bl          = bits_left_q;
		tc          = tick_q;
		ph          = phase_q;
		tc_inc      = '0;
		bit_idx     = '0;
		cur_bit     = 1'b0;

		if (s_axis_tuser == irfct_pkg::FUNC_LOAD) begin
			if (state_q == irfct_pkg::S_EMPTY || state_q == irfct_pkg::S_DONE) begin
				fire_mask_n = s_axis_tdata[1:0];
				frame_n     = load_word;
				state_n     = irfct_pkg::S_QUEUED;
				accepted_c  = 1'b1;
			end
		end else begin
			// first tick after a load starts the frame and sends its first tick
			if (state_q == irfct_pkg::S_QUEUED) begin
				bl = irfct_pkg::BITS_W'(irfct_pkg::FRAME_BITS);
				st = irfct_pkg::S_SENDING;
				tc = '0;
				ph = 1'b1;
			end
			if (st == irfct_pkg::S_SENDING) begin
				if (bl == '0) begin
					st    = irfct_pkg::S_DONE;
					pin_n = 2'b00;
				end else begin
					bit_idx = bl[irfct_pkg::IDX_W-1:0] - irfct_pkg::IDX_W'(1);
					cur_bit = frame_q[bit_idx];
					if (tc > {1'b0, pulse_half_q})
						pin_n = 2'b00;
					else if (ph && cur_bit)
						pin_n = pin_q | fire_mask_q;
					else
						pin_n = 2'b00;
					ph     = ~ph;
					tc_inc = tc + irfct_pkg::TICK_W'(1);
					if (tc_inc >= {pulse_half_q, 1'b0}) begin
						tc = '0;
						ph = 1'b1;
						bl = bl - irfct_pkg::BITS_W'(1);
					end else begin
						tc = tc_inc;
					end
				end
			end
			state_n     = st;
			bits_left_n = bl;
			tick_n      = tc;
			phase_n     = ph;
		end
	end

	always_comb begin
		unique case (state_n)
			irfct_pkg::S_EMPTY:   status_c = irfct_pkg::STATUS_EMPTY;
			irfct_pkg::S_QUEUED:  status_c = irfct_pkg::STATUS_QUEUED;
			irfct_pkg::S_SENDING: status_c = irfct_pkg::STATUS_SENDING;
			irfct_pkg::S_DONE:    status_c = irfct_pkg::STATUS_DONE;
			default:              status_c = irfct_pkg::STATUS_EMPTY;
		endcase
	end

	assign res_c.drive    = pin_n;
	assign res_c.status   = status_c;
	assign res_c.accepted = accepted_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_half_q <= irfct_pkg::PULSE_RESET;
		end else if (cfg_we) begin
			pulse_half_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= irfct_pkg::S_EMPTY;
			frame_q     <= '0;
			bits_left_q <= irfct_pkg::BITS_W'(irfct_pkg::FRAME_BITS);
			tick_q      <= '0;
			phase_q     <= 1'b1;
			fire_mask_q <= 2'b00;
			pin_q       <= 2'b00;
		end else if (in_acc) begin
			state_q     <= state_n;
			frame_q     <= frame_n;
			bits_left_q <= bits_left_n;
			tick_q      <= tick_n;
			phase_q     <= phase_n;
			fire_mask_q <= fire_mask_n;
			pin_q       <= pin_n;
		end
	end

	// output register with a skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q)
				out_data_q <= skid_data_q;
			else if (in_acc)
				out_data_q <= res_c;
		end else if (in_acc) begin
			skid_data_q <= res_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_data_q};

endmodule

// File: design/irfct_checker.sv
// Port-level checker for the IR frame carrier transmitter, bound to the top.
// Depends on irfct_pkg and ir_frame_carrier_transmitter_macros.svh.
`include "ir_frame_carrier_transmitter_macros.svh"

module irfct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	logic [1:0] drive_w;
	logic [1:0] status_w;
	logic       out_stall;
	logic       took_load;
	logic       not_sending;

	assign drive_w     = m_axis_tdata[1:0];
	assign status_w    = m_axis_tdata[3:2];
	assign out_stall   = m_axis_tvalid && !m_axis_tready;
	assign took_load   = m_axis_tvalid && m_axis_tdata[4];
	assign not_sending = m_axis_tvalid && (status_w != irfct_pkg::STATUS_SENDING);

	// input is held off only while a result is already waiting
	`IRFCT_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid)

	// a stalled result holds its value
	`IRFCT_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

	// a taken load always leaves the frame queued
	`IRFCT_ASSERT_NOW(a_accept_queues, took_load, status_w == irfct_pkg::STATUS_QUEUED)

	// emitters are off whenever nothing is being sent
	`IRFCT_ASSERT_NOW(a_idle_dark, not_sending, drive_w == 2'b00)

endmodule

bind ir_frame_carrier_transmitter irfct_checker u_irfct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
